// ===== src/palr_pkg.sv =====
// Package for the path arc-length resampler: store sizes, item and entry types,
// register indexes and pose source codes. Depends on nothing.
`default_nettype none
package palr_pkg;

	localparam int MAX_POINTS = 256;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED      = 2'd2;

	localparam logic [1:0] SRC_ROBOT  = 2'd0;
	localparam logic [1:0] SRC_FIRST  = 2'd1;
	localparam logic [1:0] SRC_LAST   = 2'd2;
	localparam logic [1:0] SRC_INTERP = 2'd3;

	localparam logic MODE_APPEND  = 1'b0;
	localparam logic MODE_TRIGGER = 1'b1;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} pose_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [15:0] out_qx;
		logic signed [15:0] out_qy;
		logic signed [15:0] out_qz;
		logic signed [15:0] out_qw;
		logic [5:0]         step_index;
		logic [1:0]         pose_source;
		logic               path_truncated;
		logic               last;
	} traj_item_t;

	// one stored path point; quaternion component k sits at quat[16k +: 16]
	typedef struct packed {
		logic [31:0] arc;
		logic [63:0] quat;
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
	} entry_t;

endpackage
`default_nettype wire

// ===== src/palr_in_if.sv =====
// Input channel of the resampler: valid/ready handshake carrying one pose item.
// Depends on palr_pkg.
`default_nettype none
interface palr_in_if;
	import palr_pkg::*;
	logic       valid;
	logic       ready;
	pose_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/palr_out_if.sv =====
// Output channel of the resampler: valid/ready handshake carrying one trajectory item.
// Depends on palr_pkg.
`default_nettype none
interface palr_out_if;
	import palr_pkg::*;
	logic       valid;
	logic       ready;
	traj_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/palr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module palr_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic                 re,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [0:D-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== src/palr_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// No package dependencies.
`default_nettype none
module palr_isqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic             busy,
	output logic             done,
	output logic      [31:0] root
);
	logic [63:0] rad_q;
	logic [35:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;
	logic [35:0] rem_sh, trial;
	logic        ge;

	assign rem_sh = {rem_q[33:0], rad_q[63:62]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rad_q  <= radicand;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= 5'd31;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rad_q <= {rad_q[61:0], 2'b00};
				if (ge) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[30:0], 1'b0};
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

// ===== src/palr_div.sv =====
// Restoring divider, 17 quotient bits, one bit per cycle.
// Caller guarantees num < den * 2^17. No package dependencies.
`default_nettype none
module palr_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [47:0] num,
	input  wire logic [31:0] den,
	output logic             busy,
	output logic             done,
	output logic      [16:0] quot
);
	logic [31:0] rem_q, den_q;
	logic [16:0] num_q, quot_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] t;
	logic        ge;

	assign t  = {rem_q, num_q[16]};
	assign ge = t >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			den_q  <= '0;
			num_q  <= '0;
			quot_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= {1'b0, num[47:17]};
				num_q  <= num[16:0];
				den_q  <= den;
				quot_q <= '0;
				cnt_q  <= 5'd16;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				num_q <= {num_q[15:0], 1'b0};
				if (ge) begin
					rem_q  <= 32'(t - {1'b0, den_q});
					quot_q <= {quot_q[15:0], 1'b1};
				end else begin
					rem_q  <= t[31:0];
					quot_q <= {quot_q[15:0], 1'b0};
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

// ===== src/path_arc_length_resampler_unit.sv =====
// Path arc-length resampler, top level. Uses palr_pkg, palr_in_if, palr_out_if,
// palr_ram, palr_isqrt and palr_div.
//
// Mode 0 items append a path pose to a 256-entry point RAM together with its running
// planar arc length; a mode 1 item (robot pose) emits step_count+1 trajectory items at
// arc positions i*speed*time_step, each the robot pose (empty path), the first point,
// the last point, or a lerp of the two neighbors with a renormalized quaternion (or the
// earlier point's quaternion for a near-zero norm), then clears the path. One item is
// worked at a time and the input is ready only while the sequencer is idle. A load
// other than the first point waits on the shared square-root unit for its segment
// length unless that saturates; a point that arrives on a full store is dropped. For
// a trajectory sample the search cursor reads RAM entries in turn (the cursor only
// moves forward within one trajectory); an interpolated sample then uses the shared
// divider for the lerp fraction, then the seven lerps, the sum of squares, the root
// and the four normalizing divides.
// The last result may still wait on the output while the next item is taken.
// No clearing pass is needed after reset: only entries below the point count are read.
`default_nettype none
module path_arc_length_resampler_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [palr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [palr_pkg::CFG_DATA_W-1:0]    cfg_data,
	palr_in_if.sink                                 pose,
	palr_out_if.source                              traj
);
	import palr_pkg::*;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_LD_SQ   = 5'd1;
	localparam logic [4:0] S_LD_SQY  = 5'd2;
	localparam logic [4:0] S_LD_SUM  = 5'd3;
	localparam logic [4:0] S_LD_ROOT = 5'd4;
	localparam logic [4:0] S_LD_WR   = 5'd5;
	localparam logic [4:0] S_T_START = 5'd6;
	localparam logic [4:0] S_SRCH_RD = 5'd7;
	localparam logic [4:0] S_SRCH_CK = 5'd8;
	localparam logic [4:0] S_LAST_CK = 5'd9;
	localparam logic [4:0] S_PREV    = 5'd10;
	localparam logic [4:0] S_TDIV    = 5'd11;
	localparam logic [4:0] S_LMUL    = 5'd12;
	localparam logic [4:0] S_LADD    = 5'd13;
	localparam logic [4:0] S_SQ      = 5'd14;
	localparam logic [4:0] S_NCHK    = 5'd15;
	localparam logic [4:0] S_NROOT   = 5'd16;
	localparam logic [4:0] S_NDIV_GO = 5'd17;
	localparam logic [4:0] S_NDIV    = 5'd18;
	localparam logic [4:0] S_EMIT    = 5'd19;
	localparam logic [4:0] S_NEXT    = 5'd20;

	// configuration
	logic [5:0]         step_count_q;
	logic [15:0]        time_step_q;
	logic signed [23:0] speed_q;

	// sequencer and path state
	logic [4:0]         state_q;
	logic [CNT_W-1:0]   count_q, cur_q;
	logic               ovf_q;
	logic [31:0]        last_x_q, last_y_q, last_arc_q, seg_q;
	logic [63:0]        sqx_q, sqy_q;

	// working pose: input latch, then the pose to emit (x, y, z, qx, qy, qz, qw)
	logic [31:0]        res_q [0:6];

	logic signed [39:0] prod_q;
	logic signed [45:0] acc_q;
	logic [5:0]         i_q;
	entry_t             ent_a_q, ent_b_q;
	logic [16:0]        t16_q;
	logic [2:0]         comp_q;
	logic signed [50:0] mprod_q;
	logic [33:0]        sumsq_q;
	logic [31:0]        nrm_q;
	logic [1:0]         src_q;

	logic               out_valid_q;
	traj_item_t         out_q;

	// RAM
	logic               mem_we, mem_re;
	logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
	entry_t             mem_wdata, rd;

	// shared units
	logic               sq_start, sq_busy, sq_done;
	logic [63:0]        sq_rad;
	logic [31:0]        sq_root;
	logic               dv_start, dv_busy, dv_done;
	logic [47:0]        dv_num;
	logic [31:0]        dv_den;
	logic [16:0]        dv_quot;

	palr_ram #(.W($bits(entry_t)), .D(MAX_POINTS)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd)
	);

	palr_isqrt u_sqrt (
		.clk (clk), .arst_n (arst_n), .start (sq_start), .radicand (sq_rad),
		.busy (sq_busy), .done (sq_done), .root (sq_root)
	);

	palr_div u_div (
		.clk (clk), .arst_n (arst_n), .start (dv_start), .num (dv_num), .den (dv_den),
		.busy (dv_busy), .done (dv_done), .quot (dv_quot)
	);

	logic               in_acc;
	logic signed [29:0] target;
	logic               arc_ge;
	logic signed [32:0] dx, dy;
	logic [32:0]        ax, ay;
	logic [64:0]        sum65;
	logic [32:0]        arc_sum;
	logic [31:0]        new_arc;
	logic [CNT_W-1:0]   cnt_m1, cur_m1;
	logic [31:0]        a_val, b_val, ladd_val;
	logic signed [32:0] ldiff;
	logic signed [50:0] lmul, lrnd;
	logic [2:0]         qidx;
	logic signed [15:0] qs;
	logic signed [32:0] qsq;
	logic [16:0]        qabs;
	logic [31:0]        tdiff;
	logic [15:0]        qnorm;

	assign in_acc = pose.valid && pose.ready;
	assign pose.ready = (state_q == S_IDLE);

	// target arc position of sample i: floor(i*prod / 2^16)
	assign target = acc_q[45:16];
	assign arc_ge = $signed({2'b00, rd.arc}) >= $signed({{4{target[29]}}, target});

	// planar segment for loads
	assign dx    = $signed({res_q[0][31], res_q[0]}) - $signed({last_x_q[31], last_x_q});
	assign dy    = $signed({res_q[1][31], res_q[1]}) - $signed({last_y_q[31], last_y_q});
	assign ax    = dx[32] ? 33'(-dx) : 33'(dx);
	assign ay    = dy[32] ? 33'(-dy) : 33'(dy);
	assign sum65 = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign arc_sum = {1'b0, last_arc_q} + {1'b0, seg_q};
	assign new_arc = (count_q == '0) ? 32'd0 : (arc_sum[32] ? 32'hFFFF_FFFF : arc_sum[31:0]);

	assign cnt_m1 = count_q - 1'b1;
	assign cur_m1 = cur_q - 1'b1;

	// lerp operands for component comp_q
	always_comb begin
		case (comp_q)
			3'd0: begin a_val = ent_a_q.x; b_val = ent_b_q.x; end
			3'd1: begin a_val = ent_a_q.y; b_val = ent_b_q.y; end
			3'd2: begin a_val = ent_a_q.z; b_val = ent_b_q.z; end
			3'd3: begin
				a_val = 32'($signed(ent_a_q.quat[15:0]));
				b_val = 32'($signed(ent_b_q.quat[15:0]));
			end
			3'd4: begin
				a_val = 32'($signed(ent_a_q.quat[31:16]));
				b_val = 32'($signed(ent_b_q.quat[31:16]));
			end
			3'd5: begin
				a_val = 32'($signed(ent_a_q.quat[47:32]));
				b_val = 32'($signed(ent_b_q.quat[47:32]));
			end
			3'd6: begin
				a_val = 32'($signed(ent_a_q.quat[63:48]));
				b_val = 32'($signed(ent_b_q.quat[63:48]));
			end
			default: begin a_val = '0; b_val = '0; end
		endcase
	end

	assign ldiff    = $signed({b_val[31], b_val}) - $signed({a_val[31], a_val});
	assign lmul     = ldiff * $signed({1'b0, t16_q});
	assign lrnd     = (mprod_q + 51'sd32768) >>> 16;
	assign ladd_val = a_val + lrnd[31:0];

	assign qidx  = comp_q + 3'd3;
	assign qs    = $signed(res_q[qidx][15:0]);
	assign qsq   = qs * qs;
	assign qabs  = qs[15] ? 17'(-$signed({qs[15], qs})) : {1'b0, qs};
	assign tdiff = 32'($signed({target[29], target[29], target})) - ent_a_q.arc;

	// round-to-nearest quotient back to a signed Q2.14 with saturation
	always_comb begin
		if (qs[15]) begin
			qnorm = (dv_quot > 17'd32768) ? 16'h8000 : 16'(-$signed({1'b0, dv_quot}));
		end else begin
			qnorm = (dv_quot > 17'd32767) ? 16'h7FFF : dv_quot[15:0];
		end
	end

	// RAM and unit control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[ADDR_W-1:0];
		mem_wdata = '{arc: new_arc, quat: {res_q[6][15:0], res_q[5][15:0],
		              res_q[4][15:0], res_q[3][15:0]}, z: res_q[2], y: res_q[1], x: res_q[0]};
		mem_re    = 1'b0;
		mem_raddr = cur_q[ADDR_W-1:0];
		sq_start  = 1'b0;
		sq_rad    = sum65[63:0];
		dv_start  = 1'b0;
		dv_num    = {tdiff, 16'h0000};
		dv_den    = ent_b_q.arc - rd.arc;
		case (state_q)
			S_LD_SUM: sq_start = !sum65[64];
			S_LD_WR:  mem_we = 1'b1;
			S_SRCH_RD: begin
				mem_re = 1'b1;
				if (cur_q >= count_q) begin
					mem_raddr = cnt_m1[ADDR_W-1:0];
				end
			end
			S_SRCH_CK: begin
				mem_re    = arc_ge && (cur_q != '0);
				mem_raddr = cur_m1[ADDR_W-1:0];
			end
			S_PREV: begin
				dv_start = 1'b1;
				dv_num   = {32'(tdiff + 32'd0 + ent_a_q.arc - rd.arc), 16'h0000};
			end
			S_NCHK: begin
				sq_start = (sumsq_q >= 34'd3);
				sq_rad   = {30'd0, sumsq_q};
			end
			S_NDIV_GO: begin
				dv_start = 1'b1;
				dv_num   = {16'h0000, 32'({1'b0, qabs, 14'd0}) + {1'b0, nrm_q[31:1]}};
				dv_den   = nrm_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= 6'd20;
			time_step_q  <= 16'd6554;
			speed_q      <= 24'sd32768;
			state_q      <= S_IDLE;
			count_q      <= '0;
			cur_q        <= '0;
			ovf_q        <= 1'b0;
			last_x_q     <= '0;
			last_y_q     <= '0;
			last_arc_q   <= '0;
			seg_q        <= '0;
			sqx_q        <= '0;
			sqy_q        <= '0;
			for (int k = 0; k < 7; k++) begin
				res_q[k] <= '0;
			end
			prod_q       <= '0;
			acc_q        <= '0;
			i_q          <= '0;
			ent_a_q      <= '0;
			ent_b_q      <= '0;
			t16_q        <= '0;
			comp_q       <= '0;
			mprod_q      <= '0;
			sumsq_q      <= '0;
			nrm_q        <= '0;
			src_q        <= SRC_ROBOT;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_STEP_COUNT: step_count_q <= cfg_data[5:0];
					REG_TIME_STEP:  time_step_q  <= cfg_data[15:0];
					REG_SPEED:      speed_q      <= $signed(cfg_data);
					default: ;
				endcase
			end

			// in S_EMIT a ready output is always refilled below
			if (traj.ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						res_q[0] <= pose.data.pos_x;
						res_q[1] <= pose.data.pos_y;
						res_q[2] <= pose.data.pos_z;
						res_q[3] <= 32'(pose.data.quat_x);
						res_q[4] <= 32'(pose.data.quat_y);
						res_q[5] <= 32'(pose.data.quat_z);
						res_q[6] <= 32'(pose.data.quat_w);
						if (pose.data.mode == MODE_APPEND) begin
							if (count_q >= CNT_W'(MAX_POINTS)) begin
								ovf_q <= 1'b1;
							end else begin
								state_q <= S_LD_SQ;
							end
						end else begin
							prod_q  <= 40'(speed_q * $signed({1'b0, time_step_q}));
							acc_q   <= '0;
							i_q     <= '0;
							cur_q   <= '0;
							state_q <= S_T_START;
						end
					end
				end
				S_LD_SQ: begin
					if (count_q == '0) begin
						state_q <= S_LD_WR;
					end else if (ax[32] || ay[32]) begin
						seg_q   <= 32'hFFFF_FFFF;
						state_q <= S_LD_WR;
					end else begin
						sqx_q   <= ax[31:0] * ax[31:0];
						state_q <= S_LD_SQY;
					end
				end
				S_LD_SQY: begin
					sqy_q   <= ay[31:0] * ay[31:0];
					state_q <= S_LD_SUM;
				end
				S_LD_SUM: begin
					if (sum65[64]) begin
						seg_q   <= 32'hFFFF_FFFF;
						state_q <= S_LD_WR;
					end else begin
						state_q <= S_LD_ROOT;
					end
				end
				S_LD_ROOT: begin
					if (sq_done) begin
						seg_q   <= sq_root;
						state_q <= S_LD_WR;
					end
				end
				S_LD_WR: begin
					last_x_q   <= res_q[0];
					last_y_q   <= res_q[1];
					last_arc_q <= new_arc;
					count_q    <= count_q + 1'b1;
					state_q    <= S_IDLE;
				end
				S_T_START: begin
					if (count_q == '0) begin
						src_q   <= SRC_ROBOT;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_SRCH_RD;
					end
				end
				S_SRCH_RD: begin
					state_q <= (cur_q >= count_q) ? S_LAST_CK : S_SRCH_CK;
				end
				S_SRCH_CK: begin
					if (arc_ge) begin
						if (cur_q == '0) begin
							res_q[0] <= rd.x;
							res_q[1] <= rd.y;
							res_q[2] <= rd.z;
							for (int k = 0; k < 4; k++) begin
								res_q[3 + k] <= 32'($signed(rd.quat[16*k +: 16]));
							end
							src_q   <= SRC_FIRST;
							state_q <= S_EMIT;
						end else begin
							ent_b_q <= rd;
							state_q <= S_PREV;
						end
					end else begin
						cur_q   <= cur_q + 1'b1;
						state_q <= S_SRCH_RD;
					end
				end
				S_LAST_CK: begin
					res_q[0] <= rd.x;
					res_q[1] <= rd.y;
					res_q[2] <= rd.z;
					for (int k = 0; k < 4; k++) begin
						res_q[3 + k] <= 32'($signed(rd.quat[16*k +: 16]));
					end
					src_q   <= SRC_LAST;
					state_q <= S_EMIT;
				end
				S_PREV: begin
					ent_a_q <= rd;
					state_q <= S_TDIV;
				end
				S_TDIV: begin
					if (dv_done) begin
						t16_q   <= dv_quot;
						comp_q  <= '0;
						state_q <= S_LMUL;
					end
				end
				S_LMUL: begin
					mprod_q <= lmul;
					state_q <= S_LADD;
				end
				S_LADD: begin
					res_q[comp_q] <= ladd_val;
					if (comp_q == 3'd6) begin
						comp_q  <= '0;
						sumsq_q <= '0;
						state_q <= S_SQ;
					end else begin
						comp_q  <= comp_q + 1'b1;
						state_q <= S_LMUL;
					end
				end
				S_SQ: begin
					sumsq_q <= sumsq_q + {1'b0, qsq};
					if (comp_q == 3'd3) begin
						state_q <= S_NCHK;
					end else begin
						comp_q <= comp_q + 1'b1;
					end
				end
				S_NCHK: begin
					if (sumsq_q >= 34'd3) begin
						state_q <= S_NROOT;
					end else begin
						// norm too small: keep the earlier point's orientation
						for (int k = 0; k < 4; k++) begin
							res_q[3 + k] <= 32'($signed(ent_a_q.quat[16*k +: 16]));
						end
						src_q   <= SRC_INTERP;
						state_q <= S_EMIT;
					end
				end
				S_NROOT: begin
					if (sq_done) begin
						nrm_q   <= sq_root;
						comp_q  <= '0;
						state_q <= S_NDIV_GO;
					end
				end
				S_NDIV_GO: begin
					state_q <= S_NDIV;
				end
				S_NDIV: begin
					if (dv_done) begin
						res_q[qidx] <= 32'($signed(qnorm));
						if (comp_q == 3'd3) begin
							src_q   <= SRC_INTERP;
							state_q <= S_EMIT;
						end else begin
							comp_q  <= comp_q + 1'b1;
							state_q <= S_NDIV_GO;
						end
					end
				end
				S_EMIT: begin
					if (!out_valid_q || traj.ready) begin
						out_valid_q          <= 1'b1;
						out_q.out_x          <= res_q[0];
						out_q.out_y          <= res_q[1];
						out_q.out_z          <= res_q[2];
						out_q.out_qx         <= res_q[3][15:0];
						out_q.out_qy         <= res_q[4][15:0];
						out_q.out_qz         <= res_q[5][15:0];
						out_q.out_qw         <= res_q[6][15:0];
						out_q.step_index     <= i_q;
						out_q.pose_source    <= src_q;
						out_q.path_truncated <= ovf_q;
						out_q.last           <= (i_q == step_count_q);
						state_q              <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (i_q == step_count_q) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						i_q     <= i_q + 1'b1;
						acc_q   <= acc_q + 46'(prod_q);
						state_q <= S_T_START;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign traj.valid = out_valid_q;
	assign traj.data  = out_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond store depth");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(traj.valid && traj.data.last) |-> (traj.data.step_index == step_count_q))
		else $error("last flag on wrong sample");

	a_write_counts: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (count_q == $past(count_q) + 1'b1))
		else $error("store write without count advance");

	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		pose.ready |-> (!sq_busy && !dv_busy))
		else $error("input taken while a unit is busy");
`endif

endmodule
`default_nettype wire
